/* sv/tgarle_pkg.sv */
// Shared types and constants for the run-length TGA pixel decoder.
`timescale 1ns / 1ps

package tgarle_pkg;

    localparam int MAX_DIM_DEFAULT = 4096;
    localparam int CFG_DATA_W      = 13;
    localparam int CFG_INDEX_W     = 2;
    localparam int INDEX_W         = 24;
    localparam int TOTAL_W         = INDEX_W + 1;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(1) << INDEX_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HAS_ALPHA    = 2'd2;

    localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;
    localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;

    // Settings that both halves of the decoder look at.
    typedef struct packed {
        logic               has_alpha;
        logic [TOTAL_W-1:0] total;
    } t_cfg;

    // One completed pixel handed from the packet parser to the run formatter.
    typedef struct packed {
        logic [31:0]        argb;
        logic [INDEX_W-1:0] start_index;
        logic [7:0]         pixels_left;
        logic               repeat_pkt;
    } t_run_cmd;

endpackage

/* sv/tgarle_front.sv */
// Packet parser: tracks headers, assembles pixels and counts decoded pixels.
`timescale 1ns / 1ps

module tgarle_front
    import tgarle_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_fire,
    input  logic [7:0]       i_data_byte,
    input  logic             i_image_start,
    output logic             o_push,
    output t_run_cmd         o_cmd
);

    logic               r_expect_header, n_expect_header;
    logic               r_repeat_pkt, n_repeat_pkt;
    logic [7:0]         r_pixels_left, n_pixels_left;
    logic [1:0]         r_byte_phase, n_byte_phase;
    logic [23:0]        r_partial, n_partial;
    logic [INDEX_W-1:0] r_pixel_count, n_pixel_count;
    logic               r_image_done, n_image_done;

    // State as seen by this byte, after an image start has cleared it.
    logic               e_expect_header;
    logic               e_repeat_pkt;
    logic [7:0]         e_pixels_left;
    logic [1:0]         e_byte_phase;
    logic [23:0]        e_partial;
    logic [INDEX_W-1:0] e_pixel_count;
    logic               e_image_done;

    logic               completes;
    logic [23:0]        color;
    logic [7:0]         alpha;
    logic [TOTAL_W-1:0] run_end;
    logic               last;
    logic [7:0]         left_after;

    always_comb begin
        if (i_image_start) begin
            e_expect_header = 1'b1;
            e_repeat_pkt    = 1'b0;
            e_pixels_left   = '0;
            e_byte_phase    = '0;
            e_partial       = '0;
            e_pixel_count   = '0;
            e_image_done    = 1'b0;
        end else begin
            e_expect_header = r_expect_header;
            e_repeat_pkt    = r_repeat_pkt;
            e_pixels_left   = r_pixels_left;
            e_byte_phase    = r_byte_phase;
            e_partial       = r_partial;
            e_pixel_count   = r_pixel_count;
            e_image_done    = r_image_done;
        end
    end

    assign completes = i_cfg.has_alpha ? (e_byte_phase == 2'd3) : (e_byte_phase >= 2'd2);
    assign color     = i_cfg.has_alpha ? e_partial : {i_data_byte, e_partial[15:0]};
    assign alpha     = i_cfg.has_alpha ? i_data_byte : ALPHA_OPAQUE;

    // A repeat run ends the image when it reaches the total; a literal pixel
    // when it is the final one.
    assign run_end    = {1'b0, e_pixel_count}
                      + (e_repeat_pkt ? {{(TOTAL_W-8){1'b0}}, e_pixels_left} : TOTAL_W'(1));
    assign last       = (run_end >= i_cfg.total);
    assign left_after = e_pixels_left - 8'd1;

    always_comb begin
        n_expect_header = e_expect_header;
        n_repeat_pkt    = e_repeat_pkt;
        n_pixels_left   = e_pixels_left;
        n_byte_phase    = e_byte_phase;
        n_partial       = e_partial;
        n_pixel_count   = e_pixel_count;
        n_image_done    = e_image_done;
        o_push          = 1'b0;
        if (!e_image_done) begin
            if ({1'b0, e_pixel_count} >= i_cfg.total) begin
                n_image_done = 1'b1;
            end else if (e_expect_header) begin
                n_repeat_pkt    = i_data_byte[7];
                n_pixels_left   = (i_data_byte & HDR_COUNT_MASK) + 8'd1;
                n_byte_phase    = '0;
                n_expect_header = 1'b0;
            end else if (!completes) begin
                case (e_byte_phase)
                    2'd0:    n_partial[7:0]   = i_data_byte;
                    2'd1:    n_partial[15:8]  = i_data_byte;
                    2'd2:    n_partial[23:16] = i_data_byte;
                    default: n_partial        = e_partial;
                endcase
                n_byte_phase = e_byte_phase + 2'd1;
            end else begin
                o_push       = 1'b1;
                n_partial    = color;
                n_byte_phase = '0;
                if (e_repeat_pkt) begin
                    n_pixels_left   = '0;
                    n_expect_header = 1'b1;
                end else begin
                    n_pixels_left = left_after;
                    if (left_after == 8'd0) begin
                        n_expect_header = 1'b1;
                    end
                end
                if (last) begin
                    n_image_done = 1'b1;
                end else begin
                    n_pixel_count = run_end[INDEX_W-1:0];
                end
            end
        end
    end

    assign o_cmd.argb        = {alpha, color};
    assign o_cmd.start_index = e_pixel_count;
    assign o_cmd.pixels_left = e_pixels_left;
    assign o_cmd.repeat_pkt  = e_repeat_pkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_header <= 1'b1;
            r_repeat_pkt    <= 1'b0;
            r_pixels_left   <= '0;
            r_byte_phase    <= '0;
            r_partial       <= '0;
            r_pixel_count   <= '0;
            r_image_done    <= 1'b0;
        end else if (i_fire) begin
            r_expect_header <= n_expect_header;
            r_repeat_pkt    <= n_repeat_pkt;
            r_pixels_left   <= n_pixels_left;
            r_byte_phase    <= n_byte_phase;
            r_partial       <= n_partial;
            r_pixel_count   <= n_pixel_count;
            r_image_done    <= n_image_done;
        end
    end

endmodule

/* sv/tgarle_queue.sv */
// Small register queue of completed pixels between parser and formatter.
`timescale 1ns / 1ps

module tgarle_queue
    import tgarle_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_run_cmd i_cmd,
    output logic     o_full,
    output logic     o_valid,
    input  logic     i_pop,
    output t_run_cmd o_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    t_run_cmd           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == LAST_SLOT) ? '0 : r_wptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST_SLOT) ? '0 : r_rptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

/* sv/tgarle_back.sv */
// Run formatter: clips runs to the image, flags the final run, drives results.
`timescale 1ns / 1ps

module tgarle_back
    import tgarle_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_cmd_valid,
    input  t_run_cmd           i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_argb,
    output logic [INDEX_W-1:0] o_start_index,
    output logic [7:0]         o_run_length,
    output logic               o_last_run
);

    logic               r_valid;
    logic [31:0]        r_argb;
    logic [INDEX_W-1:0] r_start_index;
    logic [7:0]         r_run_length;
    logic               r_last_run;

    logic [TOTAL_W-1:0] remaining;
    logic [TOTAL_W-1:0] len_wide;

    assign o_pop = i_cmd_valid && (!r_valid || i_ready);

    // The parser never issues a run at or past the total, so the remainder
    // is at least one pixel.
    assign remaining = i_cfg.total - {1'b0, i_cmd.start_index};

    always_comb begin
        if (!i_cmd.repeat_pkt) begin
            len_wide = TOTAL_W'(1);
        end else if ({{(TOTAL_W-8){1'b0}}, i_cmd.pixels_left} > remaining) begin
            len_wide = remaining;
        end else begin
            len_wide = {{(TOTAL_W-8){1'b0}}, i_cmd.pixels_left};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_argb        <= i_cmd.argb;
            r_start_index <= i_cmd.start_index;
            r_run_length  <= len_wide[7:0];
            r_last_run    <= (len_wide == remaining);
        end
    end

    assign o_valid       = r_valid;
    assign o_argb        = r_argb;
    assign o_start_index = r_start_index;
    assign o_run_length  = r_run_length;
    assign o_last_run    = r_last_run;

endmodule

/* sv/tga_rle_pixel_decoder.sv */
// Top level of the run-length TGA pixel decoder: settings, parser, queue, formatter.
`timescale 1ns / 1ps

// Decodes run-length-encoded 24 or 32 bit TGA pixel data, one byte per request,
// into runs of one colour with their linear start index, length and a flag on
// the run that completes the image. A byte is taken every cycle unless the queue
// is full: the packet parser updates its small state per byte, and a two-entry
// queue plus the run formatter's output register keep it running while results
// wait. A run is queued, then held in the run formatter's output register. Bytes
// past the end of the image are dropped until a request with image_start.
// The pixel total is worked out when a dimension is written, so settings
// take effect from the next cycle on; there is no clearing pass after reset.
module tga_rle_pixel_decoder
    import tgarle_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_image_start,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [31:0]            o_argb,
    output logic [INDEX_W-1:0]     o_start_index,
    output logic [7:0]             o_run_length,
    output logic                   o_last_run
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int PROD_W = 2 * DIM_W;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [31:0] wide;
        wide = {{(32-CFG_DATA_W){1'b0}}, v};
        if (v == '0) begin
            return DIM_W'(1);
        end else if (wide > 32'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end else begin
            return DIM_W'(wide);
        end
    endfunction

    function automatic logic [TOTAL_W-1:0] saturate_total(input logic [PROD_W-1:0] p);
        logic [PROD_W+TOTAL_W-1:0] pw;
        logic [PROD_W+TOTAL_W-1:0] lim;
        pw  = {{TOTAL_W{1'b0}}, p};
        lim = {{PROD_W{1'b0}}, TOTAL_MAX};
        if (pw > lim) begin
            return TOTAL_MAX;
        end else begin
            return pw[TOTAL_W-1:0];
        end
    endfunction

    logic [CFG_DATA_W-1:0] r_width;
    logic [CFG_DATA_W-1:0] r_height;
    logic                  r_has_alpha;
    logic [TOTAL_W-1:0]    r_total;
    logic [PROD_W-1:0]     product;
    logic [DIM_W-1:0]      mul_a, mul_b;

    t_cfg     cfg;
    logic     in_fire;
    logic     push;
    t_run_cmd push_cmd;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    t_run_cmd q_cmd;

    // One dimension comes from the write data, the other from its register.
    always_comb begin
        if (i_cfg_index == CFG_IMAGE_WIDTH) begin
            mul_a = clamp_dim(i_cfg_data);
            mul_b = clamp_dim(r_height);
        end else begin
            mul_a = clamp_dim(r_width);
            mul_b = clamp_dim(i_cfg_data);
        end
    end

    assign product = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= CFG_DATA_W'(1);
            r_height    <= CFG_DATA_W'(1);
            r_has_alpha <= 1'b0;
            r_total     <= TOTAL_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data;
                    r_total <= saturate_total(product);
                end
                CFG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data;
                    r_total  <= saturate_total(product);
                end
                CFG_HAS_ALPHA: begin
                    r_has_alpha <= i_cfg_data[0];
                end
                default: begin
                    r_total <= r_total;
                end
            endcase
        end
    end

    assign cfg.has_alpha = r_has_alpha;
    assign cfg.total     = r_total;

    assign o_ready = !q_full;
    assign in_fire = i_valid && o_ready;

    tgarle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_fire        (in_fire),
        .i_data_byte   (i_data_byte),
        .i_image_start (i_image_start),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    tgarle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && in_fire),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    tgarle_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_argb        (o_argb),
        .o_start_index (o_start_index),
        .o_run_length  (o_run_length),
        .o_last_run    (o_last_run)
    );

endmodule
